[sv/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for clocked concurrent assertions, sampled on clk_i and
// disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property checked on every rising clock edge.
`define UTF8F_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Consequent checked at the clock edge that follows the one where the antecedent holds.
`define UTF8F_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/utf8f_pkg.sv]
// ---------------------------------------------------------------------------
// UTF-8 filter package
// Types, constants and the per code point filter and encoder functions.
// ---------------------------------------------------------------------------
package utf8f_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_ALLOW_TAB       = 3'd0,
    CFG_NO_BLANK        = 3'd1,
    CFG_ASCII_ONLY      = 3'd2,
    CFG_DECIMAL_MODE    = 3'd3,
    CFG_SCIENTIFIC_MODE = 3'd4,
    CFG_HEX_MODE        = 3'd5,
    CFG_FORCE_UPPER     = 3'd6,
    CFG_KEEP_LF         = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic allow_tab;
    logic no_blank;
    logic ascii_only;
    logic decimal_mode;
    logic scientific_mode;
    logic hex_mode;
    logic force_upper;
    logic keep_lf;
  } cfg_t;

  localparam int unsigned MaxBytes = 6;

  typedef logic [20:0] point_t;

  localparam point_t Replacement = 21'h00FFFD;
  localparam point_t MaxPoint    = 21'h10FFFF;
  localparam point_t ChNul       = 21'h000000;
  localparam point_t ChTab       = 21'h000009;
  localparam point_t ChLf        = 21'h00000A;
  localparam point_t ChCr        = 21'h00000D;
  localparam point_t ChSpace     = 21'h000020;
  localparam point_t ChAsciiTop  = 21'h00007F;

  // Encoded form of one code point, byte 0 first.
  typedef struct packed {
    logic [2:0]      len;
    logic [3:0][7:0] bytes;
  } enc_t;

  // Item handed from the decoder to the result buffer.
  typedef struct packed {
    logic                     load;
    logic [2:0]               cnt;
    logic [MaxBytes-1:0][7:0] bytes;
  } ob_load_t;

  // True when the code point survives dropping and the class rules.
  function automatic logic point_ok(point_t c, cfg_t cfg);
    logic ok;
    logic digit;
    logic op;
    logic sci;
    logic hx;
    ok    = 1'b1;
    digit = (c >= 21'h30) && (c <= 21'h39);
    op    = (c == 21'h2B) || (c == 21'h2D) || (c == 21'h2A) || (c == 21'h2F) ||
            (c == 21'h2E);
    sci   = (c == 21'h65) || (c == 21'h45);
    hx    = ((c >= 21'h61) && (c <= 21'h66)) || ((c >= 21'h41) && (c <= 21'h46)) ||
            (c == 21'h78) || (c == 21'h58);
    if (c == ChCr) ok = 1'b0;
    if ((c == ChLf) && !cfg.keep_lf) ok = 1'b0;
    if (c == ChNul) ok = 1'b0;
    if (!cfg.allow_tab && (c == ChTab)) ok = 1'b0;
    if (cfg.no_blank && ((c == ChSpace) || (c == ChTab))) ok = 1'b0;
    if (cfg.ascii_only && (c > ChAsciiTop)) ok = 1'b0;
    if (cfg.decimal_mode || cfg.scientific_mode) begin
      if (!digit && !op && !(cfg.scientific_mode && sci)) ok = 1'b0;
    end else if (cfg.hex_mode) begin
      if (!digit && !hx) ok = 1'b0;
    end
    return ok;
  endfunction

  // Optional upper-casing of a to z.
  function automatic point_t upcase(point_t c, cfg_t cfg);
    point_t r;
    r = c;
    if (cfg.force_upper && (c >= 21'h61) && (c <= 21'h7A)) r = c - 21'h20;
    return r;
  endfunction

  // UTF-8 encoding; points above the Unicode range give no bytes.
  function automatic enc_t encode(point_t c);
    enc_t e;
    e.len   = 3'd0;
    e.bytes = '0;
    if (c <= ChAsciiTop) begin
      e.len      = 3'd1;
      e.bytes[0] = c[7:0];
    end else if (c <= 21'h0007FF) begin
      e.len      = 3'd2;
      e.bytes[0] = {3'b110, c[10:6]};
      e.bytes[1] = {2'b10, c[5:0]};
    end else if (c <= 21'h00FFFF) begin
      e.len      = 3'd3;
      e.bytes[0] = {4'b1110, c[15:12]};
      e.bytes[1] = {2'b10, c[11:6]};
      e.bytes[2] = {2'b10, c[5:0]};
    end else if (c <= MaxPoint) begin
      e.len      = 3'd4;
      e.bytes[0] = {5'b11110, c[20:18]};
      e.bytes[1] = {2'b10, c[17:12]};
      e.bytes[2] = {2'b10, c[11:6]};
      e.bytes[3] = {2'b10, c[5:0]};
    end
    return e;
  endfunction

endpackage

[sv/utf8f_cfg_regs.sv]
// ---------------------------------------------------------------------------
// UTF-8 filter configuration registers
// Eight one-bit mode registers written through the configuration channel.
// ---------------------------------------------------------------------------
module utf8f_cfg_regs (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [2:0]       wr_index_i,
  input  logic             wr_data_i,
  output utf8f_pkg::cfg_t  cfg_o
);
  import utf8f_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  // Decode the register index of a write.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (cfg_idx_e'(wr_index_i))
        CFG_ALLOW_TAB:       cfg_d.allow_tab       = wr_data_i;
        CFG_NO_BLANK:        cfg_d.no_blank        = wr_data_i;
        CFG_ASCII_ONLY:      cfg_d.ascii_only      = wr_data_i;
        CFG_DECIMAL_MODE:    cfg_d.decimal_mode    = wr_data_i;
        CFG_SCIENTIFIC_MODE: cfg_d.scientific_mode = wr_data_i;
        CFG_HEX_MODE:        cfg_d.hex_mode        = wr_data_i;
        CFG_FORCE_UPPER:     cfg_d.force_upper     = wr_data_i;
        CFG_KEEP_LF:         cfg_d.keep_lf         = wr_data_i;
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[sv/utf8f_decode.sv]
// ---------------------------------------------------------------------------
// UTF-8 filter decoder
// Input register, sequence state, filtering and re-encoding of one item.
// ---------------------------------------------------------------------------
module utf8f_decode (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  utf8f_pkg::cfg_t     cfg_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          in_byte_i,
  input  logic                in_eot_i,
  input  logic                ob_free_i,
  output utf8f_pkg::ob_load_t ob_o
);
  import utf8f_pkg::*;

  logic       in_valid_q;
  logic       in_valid_d;
  logic [7:0] in_byte_q;
  logic       in_eot_q;
  logic [1:0] trail_q;
  logic [1:0] trail_d;
  point_t     part_q;
  point_t     part_d;
  point_t     part_t;
  logic       lead_go;
  logic       cp0_v;
  logic       cp1_v;
  point_t     cp1;
  point_t     cp1_up;
  enc_t       enc0;
  enc_t       enc1;
  logic [2:0] len0;
  logic [2:0] len1;
  logic [3:0] total;
  logic [2:0] k;
  logic [MaxBytes-1:0][7:0] bytes;
  logic       process;

  // Sequence decoding: at most a broken-sequence replacement followed by
  // one further code point (lead result, completed point or cut-short mark).
  always_comb begin
    trail_d = trail_q;
    part_d  = part_q;
    part_t  = {part_q[14:0], in_byte_q[5:0]};
    lead_go = 1'b0;
    cp0_v   = 1'b0;
    cp1_v   = 1'b0;
    cp1     = Replacement;
    if (trail_q != 2'd0) begin
      if (in_byte_q[7:6] == 2'b10) begin
        trail_d = trail_q - 2'd1;
        if (trail_d == 2'd0) begin
          cp1_v  = 1'b1;
          cp1    = part_t;
          part_d = '0;
        end else begin
          part_d = part_t;
        end
      end else begin
        cp0_v   = 1'b1;
        trail_d = 2'd0;
        part_d  = '0;
        lead_go = 1'b1;
      end
    end else begin
      lead_go = 1'b1;
    end
    if (lead_go) begin
      if (!in_byte_q[7]) begin
        cp1_v = 1'b1;
        cp1   = {13'd0, in_byte_q};
      end else if (in_byte_q[7:5] == 3'b110) begin
        part_d  = {16'd0, in_byte_q[4:0]};
        trail_d = 2'd1;
      end else if (in_byte_q[7:4] == 4'b1110) begin
        part_d  = {17'd0, in_byte_q[3:0]};
        trail_d = 2'd2;
      end else if (in_byte_q[7:3] == 5'b11110) begin
        part_d  = {18'd0, in_byte_q[2:0]};
        trail_d = 2'd3;
      end else begin
        cp1_v = 1'b1;
        cp1   = Replacement;
      end
    end
    // A sequence still open at the end of the text is replaced.
    if (in_eot_q && (trail_d != 2'd0)) begin
      trail_d = 2'd0;
      part_d  = '0;
      cp1_v   = 1'b1;
      cp1     = Replacement;
    end
  end

  // Filter and encode both code points.
  always_comb begin
    cp1_up = upcase(cp1, cfg_i);
    enc0   = encode(upcase(Replacement, cfg_i));
    enc1   = encode(cp1_up);
    len0   = (cp0_v && point_ok(Replacement, cfg_i)) ? enc0.len : 3'd0;
    len1   = (cp1_v && point_ok(cp1, cfg_i)) ? enc1.len : 3'd0;
    total  = {1'b0, len0} + {1'b0, len1};
  end

  // Concatenate the two encodings into the result byte list.
  always_comb begin
    k     = '0;
    bytes = '0;
    for (int j = 0; j < MaxBytes; j++) begin
      if (3'(j) < len0) begin
        bytes[j] = enc0.bytes[2'(j)];
      end else begin
        k = 3'(j) - len0;
        if (k < 3'd4) bytes[j] = enc1.bytes[k[1:0]];
      end
    end
  end

  // An item with no bytes leaves at once; otherwise it waits for the buffer.
  assign process    = in_valid_q && ((total == 4'd0) || ob_free_i);
  assign in_ready_o = !in_valid_q || process;
  assign in_valid_d = in_ready_o ? in_valid_i : in_valid_q;

  always_comb begin
    ob_o.load  = process && (total != 4'd0);
    ob_o.cnt   = (total > 4'(MaxBytes)) ? 3'(MaxBytes) : total[2:0];
    ob_o.bytes = bytes;
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      trail_q    <= 2'd0;
      part_q     <= '0;
    end else begin
      in_valid_q <= in_valid_d;
      if (process) begin
        trail_q <= trail_d;
        part_q  <= part_d;
      end
    end
  end

  // Input payload register.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= in_byte_i;
      in_eot_q  <= in_eot_i;
    end
  end

endmodule

[sv/utf8f_out_buf.sv]
// ---------------------------------------------------------------------------
// UTF-8 filter result buffer
// Holds the bytes of one item and shifts them out one per accepted output transfer.
// ---------------------------------------------------------------------------
module utf8f_out_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  utf8f_pkg::ob_load_t ld_i,
  output logic                free_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          out_byte_o,
  output logic                out_last_o
);
  import utf8f_pkg::*;

  logic [MaxBytes-1:0][7:0] bytes_q;
  logic [MaxBytes-1:0][7:0] bytes_d;
  logic [2:0]               cnt_q;
  logic [2:0]               cnt_d;
  logic                     pop;

  assign pop    = (cnt_q != 3'd0) && out_ready_i;
  assign free_o = (cnt_q == 3'd0) || ((cnt_q == 3'd1) && out_ready_i);

  // Load a new item or shift the oldest byte out.
  always_comb begin
    bytes_d = bytes_q;
    cnt_d   = cnt_q;
    if (ld_i.load) begin
      bytes_d = ld_i.bytes;
      cnt_d   = ld_i.cnt;
    end else if (pop) begin
      bytes_d = {8'h00, bytes_q[MaxBytes-1:1]};
      cnt_d   = cnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 3'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bytes_q <= bytes_d;
  end

  assign out_valid_o = cnt_q != 3'd0;
  assign out_byte_o  = bytes_q[0];
  assign out_last_o  = cnt_q == 3'd1;

endmodule

[sv/utf8_text_input_filter.sv]
// ---------------------------------------------------------------------------
// UTF-8 text input filter
// Decodes a UTF-8 byte stream, filters each code point and re-encodes it.
//
//   Channel   Direction  Signals                          Content
//   s_axis    in         tvalid tready tdata[7:0] tlast   in_byte, end_of_text
//   m_axis    out        tvalid tready tdata[7:0] tlast   out_byte, last_of_run
//   cfg       in         cfg_valid_i cfg_ready_o          index, one data bit
//
// An input item is decoded in the cycle after it is registered and its
// bytes (0 to 6) are loaded into the result buffer once it is free; the
// buffer sends one byte per cycle while m_axis_tready is high.
// Items producing no bytes are consumed at once and never wait on the output.
// Reset clears the sequence state, the mode registers and both valid flags.
// Output stalls back up through the buffer into the input register.
// ---------------------------------------------------------------------------
module utf8_text_input_filter (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [2:0] cfg_index_i,
  input  logic       cfg_data_i
);
  import utf8f_pkg::*;

  cfg_t     cfg;
  ob_load_t ob_load;
  logic     ob_free;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  utf8f_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  utf8f_decode u_decode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_byte_i  (s_axis_tdata),
    .in_eot_i   (s_axis_tlast),
    .ob_free_i  (ob_free),
    .ob_o       (ob_load)
  );

  utf8f_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ld_i        (ob_load),
    .free_o      (ob_free),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

[sv/utf8f_checker.sv]
// ---------------------------------------------------------------------------
// UTF-8 filter port checker
// Checks output handshake behaviour and the shape of the emitted UTF-8 runs.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module utf8f_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast
);

  // A stalled output item stays offered and unchanged.
  `UTF8F_ASSERT_NEXT(a_out_valid_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "output valid dropped while stalled")
  `UTF8F_ASSERT_NEXT(a_out_data_hold, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tlast), "output item changed while stalled")

  // A run never ends on a lead byte.
  `UTF8F_ASSERT(a_last_not_lead, m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[7:6] != 2'b11, "run ends on a lead byte")

  // A sent lead byte is followed by a trail byte or by no valid byte.
  `UTF8F_ASSERT_NEXT(a_lead_then_trail, m_axis_tvalid && m_axis_tready && (m_axis_tdata[7:6] == 2'b11), !m_axis_tvalid || (m_axis_tdata[7:6] == 2'b10), "lead byte not followed by trail")

endmodule

bind utf8_text_input_filter utf8f_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
